FILE: hdl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define SCPU_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("scpu assertion failed");
// condition must never be seen at a rising clock edge outside reset
`define SCPU_NEVER(name, clk, rstn, cond) \
  `SCPU_ASSERT(name, clk, rstn, !(cond))
`else
`define SCPU_ASSERT(name, clk, rstn, prop)
`define SCPU_NEVER(name, clk, rstn, cond)
`endif

`endif

FILE: hdl/scpu_pkg.sv
package scpu_pkg;

  // field widths
  localparam int ANGLE_W  = 21;
  localparam int RESULT_W = 16;

  // default fixed-point formats
  localparam int ANGLE_FRAC_BITS_DEF  = 16;
  localparam int RESULT_FRAC_BITS_DEF = 14;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // internal polynomial format
  localparam int WQ = 28;
  localparam int PW = 32;

  // pi with 61 fraction bits
  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;

  // series coefficients in q28, rounded to nearest
  localparam logic [PW-1:0] ONE_Q  = PW'(64'd1 << WQ);
  localparam logic [PW-1:0] INV6   = PW'(((64'd1 << WQ) + 64'd3) / 64'd6);
  localparam logic [PW-1:0] INV120 = PW'(((64'd1 << WQ) + 64'd60) / 64'd120);
  localparam logic [PW-1:0] INV24  = PW'(((64'd1 << WQ) + 64'd12) / 64'd24);
  localparam logic [PW-1:0] INV720 = PW'(((64'd1 << WQ) + 64'd360) / 64'd720);

  // classified angle handed from front to back
  typedef struct packed {
    logic               neg;
    logic               zero;
    logic [ANGLE_W-1:0] mag_m1;
  } item_t;

  // queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: hdl/scpu_front.sv
module scpu_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [scpu_pkg::ANGLE_W-1:0] angle_i,
  output logic                    item_valid_o,
  input  logic                    item_ready_i,
  output scpu_pkg::item_t         item_o
);
  import scpu_pkg::*;

  logic                vld_q, vld_d;
  item_t               item_q, item_d;
  logic [ANGLE_W-1:0]  mag;
  logic                accept;

  assign in_ready_o   = !vld_q || item_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign item_valid_o = vld_q;
  assign item_o       = item_q;

  // sign, magnitude and zero detect
  always_comb begin
    mag           = angle_i[ANGLE_W-1] ? (~angle_i + ANGLE_W'(1)) : angle_i;
    item_d.neg    = angle_i[ANGLE_W-1];
    item_d.zero   = (angle_i == '0);
    item_d.mag_m1 = mag - ANGLE_W'(1);
  end

  // holding register valid
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (item_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: hdl/scpu_queue.sv
module scpu_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_valid_i,
  output logic                    push_ready_o,
  input  scpu_pkg::item_t         push_item_i,
  output logic                    pop_valid_o,
  input  logic                    pop_ready_i,
  output scpu_pkg::item_t         pop_item_o,
  output scpu_pkg::queue_status_t status_o
);
  import scpu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o    = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o     = (cnt_q != '0);
  assign push            = push_valid_i && push_ready_o;
  assign pop             = pop_valid_o && pop_ready_i;
  assign pop_item_o      = mem_q[rd_ptr_q];
  assign status_o.full   = !push_ready_o;
  assign status_o.empty  = !pop_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hdl/scpu_back.sv
module scpu_back #(
  parameter int ANGLE_FRAC_BITS  = scpu_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = scpu_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  scpu_pkg::item_t               item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [scpu_pkg::RESULT_W-1:0] sine_o,
  output logic [scpu_pkg::RESULT_W-1:0] cosine_o
);
  import scpu_pkg::*;

  // angle constants in the input format
  localparam logic [63:0] PI_A64 =
    (PI_Q61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO_PI_A64 = 64'd2 * PI_A64;
  localparam logic [63:0] HALF_PI_A64 =
    (PI_Q61 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);

  // width that holds 2*pi and any magnitude
  localparam int WW = (ANGLE_FRAC_BITS + 3 > ANGLE_W) ? ANGLE_FRAC_BITS + 3 : ANGLE_W;
  localparam logic [WW-1:0] PI_A      = WW'(PI_A64);
  localparam logic [WW-1:0] TWO_PI_A  = WW'(TWO_PI_A64);
  localparam logic [WW-1:0] HALF_PI_A = WW'(HALF_PI_A64);

  // reciprocal of 2*pi for the turn count estimate
  localparam int RK = 22;
  localparam logic [RK-1:0] RECIP = RK'((64'd1 << RK) / TWO_PI_A64);

  // output rounding and saturation
  localparam int SW = 35;
  localparam int OS = WQ - RESULT_FRAC_BITS;
  localparam logic signed [SW-1:0] RND    = SW'(64'd1 << (OS - 1));
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

  function automatic logic [PW-1:0] qmul(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [2*PW-1:0] p;
    p = {{PW{1'b0}}, a} * {{PW{1'b0}}, b} + (64'd1 << (WQ - 1));
    return p[WQ+PW-1:WQ];
  endfunction

  function automatic logic [RESULT_W-1:0] finish(input logic signed [SW-1:0] v,
                                                 input logic neg);
    logic signed [SW-1:0] r;
    r = (v + RND) >>> OS;
    if (neg) begin
      r = -r;
    end
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[RESULT_W-1:0];
  endfunction

  logic       adv;
  logic [8:0] vld_q;
  logic       out_vld_q;

  // stage 1: turn estimate product
  logic [ANGLE_W+RK-1:0] p1_q;
  logic [ANGLE_W-1:0]    x1_q;
  logic                  z1_q, n1_q;
  // stage 2: turns times 2*pi
  logic [WW:0]           qt2_q;
  logic [ANGLE_W-1:0]    x2_q;
  logic                  z2_q, n2_q;
  logic [ANGLE_W+WW-1:0] qt_full;
  // stage 3: wrapped magnitude
  logic [WW-1:0]         m3_q;
  logic                  n3_q;
  logic [WW:0]           r_w, rc_w;
  // stage 4: folded angles
  logic [WW-1:0]         ms4_q, mc4_q, ms_w, mc_w;
  logic                  sn4_q, cn4_q, sn_w, cn_w;
  // stage 5: q28 angle and its square
  logic [PW-1:0]         sx5_q, sx2_5_q, cx2_5_q, sx_w, cx_w;
  logic                  sn5_q, cn5_q;
  // stage 6: cube and fourth power
  logic [PW-1:0]         sx6_q, sx2_6_q, sx3_6_q, cx4_6_q, cx2_6_q, ch6_q;
  logic                  sn6_q, cn6_q;
  // stage 7: fifth and sixth power, first terms
  logic [PW-1:0]         sx7_q, sx5_7_q, st6_7_q, cx6_7_q, ct24_7_q, ch7_q;
  logic                  sn7_q, cn7_q;
  // stage 8: last terms
  logic [PW-1:0]         sx8_q, st6_8_q, st120_8_q, ch8_q, ct24_8_q, ct720_8_q;
  logic                  sn8_q, cn8_q;
  // stage 9: polynomial sums
  logic signed [SW-1:0]  ssum9_q, csum9_q;
  logic                  sn9_q, cn9_q;
  // output register
  logic [RESULT_W-1:0]   sine_q, cosine_q;

  assign adv          = !out_vld_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = out_vld_q;
  assign sine_o       = sine_q;
  assign cosine_o     = cosine_q;

  // stage valid bits, all frozen while the output is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[7:0], item_valid_i};
      out_vld_q <= vld_q[8];
    end
  end

  // turn removal arithmetic
  always_comb begin
    qt_full = (ANGLE_W+WW)'(p1_q[ANGLE_W+RK-1:RK]) * (ANGLE_W+WW)'(TWO_PI_A);
    r_w     = (WW+1)'(x2_q) - qt2_q;
    rc_w    = (r_w >= {1'b0, TWO_PI_A}) ? r_w - {1'b0, TWO_PI_A} : r_w;
  end

  // quadrant folding for both outputs
  always_comb begin
    sn_w = n3_q;
    ms_w = m3_q;
    if (m3_q > PI_A) begin
      sn_w = !n3_q;
      ms_w = m3_q - PI_A;
    end
    if (ms_w > HALF_PI_A) begin
      ms_w = PI_A - ms_w;
    end
    cn_w = 1'b0;
    mc_w = (m3_q > PI_A) ? TWO_PI_A - m3_q : m3_q;
    if (mc_w > HALF_PI_A) begin
      cn_w = 1'b1;
      mc_w = PI_A - mc_w;
    end
    sx_w = PW'(ms4_q) << (WQ - ANGLE_FRAC_BITS);
    cx_w = PW'(mc4_q) << (WQ - ANGLE_FRAC_BITS);
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q      <= (ANGLE_W+RK)'(item_i.mag_m1) * (ANGLE_W+RK)'(RECIP);
      x1_q      <= item_i.mag_m1;
      z1_q      <= item_i.zero;
      n1_q      <= item_i.neg;

      qt2_q     <= qt_full[WW:0];
      x2_q      <= x1_q;
      z2_q      <= z1_q;
      n2_q      <= n1_q;

      m3_q      <= z2_q ? '0 : rc_w[WW-1:0] + WW'(1);
      n3_q      <= n2_q;

      ms4_q     <= ms_w;
      mc4_q     <= mc_w;
      sn4_q     <= sn_w;
      cn4_q     <= cn_w;

      sx5_q     <= sx_w;
      sx2_5_q   <= qmul(sx_w, sx_w);
      cx2_5_q   <= qmul(cx_w, cx_w);
      sn5_q     <= sn4_q;
      cn5_q     <= cn4_q;

      sx6_q     <= sx5_q;
      sx2_6_q   <= sx2_5_q;
      sx3_6_q   <= qmul(sx5_q, sx2_5_q);
      cx2_6_q   <= cx2_5_q;
      cx4_6_q   <= qmul(cx2_5_q, cx2_5_q);
      ch6_q     <= (cx2_5_q + PW'(1)) >> 1;
      sn6_q     <= sn5_q;
      cn6_q     <= cn5_q;

      sx7_q     <= sx6_q;
      sx5_7_q   <= qmul(sx3_6_q, sx2_6_q);
      st6_7_q   <= qmul(sx3_6_q, INV6);
      cx6_7_q   <= qmul(cx4_6_q, cx2_6_q);
      ct24_7_q  <= qmul(cx4_6_q, INV24);
      ch7_q     <= ch6_q;
      sn7_q     <= sn6_q;
      cn7_q     <= cn6_q;

      sx8_q     <= sx7_q;
      st6_8_q   <= st6_7_q;
      st120_8_q <= qmul(sx5_7_q, INV120);
      ch8_q     <= ch7_q;
      ct24_8_q  <= ct24_7_q;
      ct720_8_q <= qmul(cx6_7_q, INV720);
      sn8_q     <= sn7_q;
      cn8_q     <= cn7_q;

      ssum9_q   <= $signed({3'b000, sx8_q}) - $signed({3'b000, st6_8_q})
                 + $signed({3'b000, st120_8_q});
      csum9_q   <= $signed({3'b000, ONE_Q}) - $signed({3'b000, ch8_q})
                 + $signed({3'b000, ct24_8_q}) - $signed({3'b000, ct720_8_q});
      sn9_q     <= sn8_q;
      cn9_q     <= cn8_q;

      sine_q    <= finish(ssum9_q, sn9_q);
      cosine_q  <= finish(csum9_q, cn9_q);
    end
  end

endmodule

FILE: hdl/sine_cosine_polynomial_unit.sv
// channel   dir  tdata bits (lowest first)               handshake
// s_axis    in   [20:0] angle, [23:21] zero               tvalid/tready
// m_axis    out  [15:0] sine_value, [31:16] cosine_value  tvalid/tready
//
// one transaction per clock sustained while m_axis is not stalled; from input
// acceptance to output valid: the front register loads at acceptance, then one
// queue write and ten back stages (two multiply stages for the turn count,
// wrap, fold, four product stages, sum, output register)
// reset clears the front, queue and stage valid bits at once; no clearing pass
// an output stall freezes the whole back pipeline; the four-entry queue and the
// front register keep taking input until they fill
`include "assert_macros.svh"

module sine_cosine_polynomial_unit #(
  parameter int ANGLE_FRAC_BITS  = scpu_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = scpu_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [20:0] angle, [23:21] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [15:0] sine_value, [31:16] cosine_value
);
  import scpu_pkg::*;

  logic                front_valid, q_push_ready;
  item_t               front_item, q_item;
  logic                q_pop_valid, back_ready;
  queue_status_t       q_status;
  logic [RESULT_W-1:0] sine, cosine;

  // classify incoming angles
  scpu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .angle_i      (s_axis_tdata[ANGLE_W-1:0]),
    .item_valid_o (front_valid),
    .item_ready_i (q_push_ready),
    .item_o       (front_item)
  );

  // decoupling queue
  scpu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (q_push_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (q_item),
    .status_o     (q_status)
  );

  // range reduction and series evaluation
  scpu_back #(
    .ANGLE_FRAC_BITS  (ANGLE_FRAC_BITS),
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_pop_valid),
    .item_ready_o (back_ready),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .sine_o       (sine),
    .cosine_o     (cosine)
  );

  assign m_axis_tdata = {cosine, sine};

  // checks
  `SCPU_NEVER(a_no_pop_in_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready && back_ready)
  `SCPU_ASSERT(a_accept_loads_front, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> front_valid)
  `SCPU_ASSERT(a_full_has_item, clk_i, rst_ni, q_status.full |-> (q_pop_valid && !q_status.empty))

endmodule
